// ----- src/ece_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared types, register codes, state encoding and arithmetic helpers.
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int DATA_W    = 16;
    localparam int Q_W       = 17;
    localparam int QUEUE_DEP = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEP);
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = 18;
    localparam int MUL_W     = MUL_A_W + MUL_B_W;

    localparam logic [Q_W-1:0] Q_ONE  = 17'd65536;
    localparam logic [Q_W-1:0] Q_HALF = 17'd32768;

    // Configuration register indexes
    localparam logic [1:0] REG_CURVE_KIND = 2'd0;
    localparam logic [1:0] REG_EASE_MODE  = 2'd1;
    localparam logic [1:0] REG_POLY_POWER = 2'd2;

    // Curve kinds
    localparam logic [2:0] CK_LINEAR   = 3'd0;
    localparam logic [2:0] CK_QUAD     = 3'd1;
    localparam logic [2:0] CK_CUBIC    = 3'd2;
    localparam logic [2:0] CK_SINE     = 3'd3;
    localparam logic [2:0] CK_CIRCULAR = 3'd4;
    localparam logic [2:0] CK_POWER    = 3'd5;

    // Ease modes
    localparam logic [1:0] EM_IN     = 2'd0;
    localparam logic [1:0] EM_OUT    = 2'd1;
    localparam logic [1:0] EM_IN_OUT = 2'd2;
    localparam logic [1:0] EM_OUT_IN = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_OUTSIDE   = 2'd2;

    // Sine polynomial coefficients, Q30, highest order last
    localparam logic signed [MUL_A_W-1:0] SINE_COEF [5] = '{
        35'sd1686629713, -35'sd693598669, 35'sd85569306, -35'sd5026995, 35'sd172273
    };

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic [DATA_W-1:0] range_start;
        logic [DATA_W-1:0] range_end;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] eased_value;
        logic [1:0]        status;
    } out_item_t;

    typedef struct packed {
        logic [2:0] curve_kind;
        logic [1:0] ease_mode;
        logic [7:0] poly_power;
    } cfg_t;

    // One classified item waiting for the back end
    typedef struct packed {
        logic              direct;
        logic [DATA_W-1:0] value;
        logic [1:0]        status;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] offset;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MODE,
        S_QUAD,
        S_CUB1,
        S_CUB2,
        S_SIN_X2,
        S_SIN_H,
        S_SIN_F,
        S_CIRC_SQ,
        S_SQRT,
        S_POW,
        S_POST,
        S_SCALE
    } back_state_t;

    // Arithmetic shift right with rounding to nearest, halves away from zero.
    function automatic logic signed [MUL_W-1:0] rshift_rnd(
        input logic signed [MUL_W-1:0] v,
        input int unsigned             n
    );
        logic [MUL_W-1:0] mag;
        logic [MUL_W-1:0] half;
        logic [MUL_W-1:0] r;
        half = {{(MUL_W-1){1'b0}}, 1'b1} << (n - 1);
        mag  = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
        r    = (mag + half) >> n;
        return v[MUL_W-1] ? $signed(-r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

// ----- src/easing_curve_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Eases a position within a range through a configurable curve and mode.
// ----------------------------------------------------------------------------
// Edge and error items go from the queue head straight to the result register;
// curve items pass through the 32-step normalizing divider, the curve steps
// and the scaling steps. The back end takes one edge or error item per cycle
// while idle and holds the queue while it works on a curve item; a 4-entry
// queue takes beats meanwhile and busy rises only when it is full. Results
// cannot be stalled. Reset clears queue, sequencer and configuration registers.
module easing_curve_evaluator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ece_pkg::in_item_t  item,
    output logic                    busy,
    output logic                    result_valid,
    output ece_pkg::out_item_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);
    import ece_pkg::*;

    cfg_t            cfg_reg;
    logic            push;
    logic            pop;
    job_t            push_job;
    job_t            head_job;
    logic            q_empty;
    logic            q_full;
    logic [QPTR_W:0] q_count;

    // Configuration registers, written in any cycle.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_kind <= CK_LINEAR;
            cfg_reg.ease_mode  <= EM_IN;
            cfg_reg.poly_power <= 8'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CURVE_KIND: cfg_reg.curve_kind <= cfg_data[2:0];
                REG_EASE_MODE:  cfg_reg.ease_mode  <= cfg_data[1:0];
                REG_POLY_POWER: cfg_reg.poly_power <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Front end classifies beats into jobs.
    ece_front u_front (
        .start      (start),
        .item       (item),
        .queue_full (q_full),
        .busy       (busy),
        .push       (push),
        .job        (push_job)
    );

    // Job queue between front and back.
    ece_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    // Back end evaluates jobs in order.
    ece_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_job     (head_job),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // An error result always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.eased_value == '0))
        else $error("error result with nonzero value");

    // The queue fill follows pushes and pops exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (q_count == $past(q_count) + (QPTR_W+1)'($past(push))
                                       - (QPTR_W+1)'($past(pop))))
        else $error("queue count mismatch");

    // No pop from an empty queue and no push into a full one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty) && !(push && q_full))
        else $error("queue overrun or underrun");
`endif

endmodule
`default_nettype wire

// ----- src/ece_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator front end
// Accepts input beats, settles edge and error cases, and forms queue jobs.
// ----------------------------------------------------------------------------
module ece_front (
    input  wire logic            start,
    input  wire ece_pkg::in_item_t item,
    input  wire logic            queue_full,
    output logic                 busy,
    output logic                 push,
    output ece_pkg::job_t        job
);
    import ece_pkg::*;

    // Accept a beat whenever the queue has room.
    assign busy = queue_full;
    assign push = start && !queue_full;

    // Classify the item in the order edge start, edge end, range, position.
    always_comb
    begin
        job.direct = 1'b1;
        job.value  = '0;
        job.status = ST_OK;
        job.lo     = item.range_start;
        job.span   = item.range_end - item.range_start;
        job.offset = item.position - item.range_start;
        if (item.position == item.range_start)
        begin
            job.value = item.range_start;
        end
        else if (item.position == item.range_end)
        begin
            job.value = item.range_end;
        end
        else if (item.range_end < item.range_start)
        begin
            job.status = ST_BAD_RANGE;
        end
        else if (item.position < item.range_start || item.position > item.range_end)
        begin
            job.status = ST_OUTSIDE;
        end
        else
        begin
            job.direct = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- src/ece_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator job queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ece_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ece_pkg::job_t push_job,
    input  wire logic          pop,
    output ece_pkg::job_t      head_job,
    output logic               empty,
    output logic               full,
    output logic [ece_pkg::QPTR_W:0] count
);
    import ece_pkg::*;

    job_t              slot_reg [QUEUE_DEP];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEP));
    assign count    = count_reg;
    assign head_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- src/ece_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator back end
// Sequencer that normalizes, evaluates the curve and scales each curve job;
// edge and error jobs pass straight to the result.
module ece_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ece_pkg::cfg_t cfg,
    input  wire ece_pkg::job_t head_job,
    input  wire logic          empty,
    output logic               pop,
    output logic               result_valid,
    output ece_pkg::out_item_t result
);
    import ece_pkg::*;

    back_state_t                 state_reg, state_next;
    job_t                        job_reg, job_next;
    logic [7:0]                  cnt_reg, cnt_next;
    logic [31:0]                 num_reg, num_next;
    logic [DATA_W-1:0]           rem_reg, rem_next;
    logic                        flip_reg, flip_next;
    logic                        split_reg, split_next;
    logic                        upper_reg, upper_next;
    logic [Q_W-1:0]              x_reg, x_next;
    logic [Q_W-1:0]              cin_reg, cin_next;
    logic signed [MUL_A_W-1:0]   a_reg, a_next;
    logic signed [MUL_B_W-1:0]   b_reg, b_next;
    logic [33:0]                 sq_v_reg, sq_v_next;
    logic [33:0]                 sq_res_reg, sq_res_next;
    logic [33:0]                 sq_bit_reg, sq_bit_next;
    logic                        rv_reg, rv_next;
    out_item_t                   res_reg, res_next;

    logic signed [MUL_W-1:0]     mul;
    logic [DATA_W:0]             rem_shift;
    logic                        div_fits;
    logic [Q_W-1:0]              u_val;
    logic [Q_W:0]                v_wide;
    logic [Q_W-1:0]              v_val;
    logic                        use_in;
    logic                        split_val;
    logic                        upper_val;
    logic [Q_W-1:0]              xi;
    logic [Q_W-1:0]              xs;
    logic signed [MUL_W-1:0]     rs_val;
    logic signed [MUL_A_W-1:0]   horner;
    logic [MUL_W-1:0]            mul_rnd16;
    logic [MUL_W-1:0]            mul_rnd32;
    logic [Q_W-1:0]              sine_p;
    logic [33:0]                 sq_try;
    logic                        sq_take;
    logic [33:0]                 sq_res_step;
    logic [Q_W-1:0]              c_val;
    logic [Q_W:0]                g_half;
    logic [Q_W-1:0]              g_val;

    // Shared multiplier; every consumer registers its result.
    assign mul       = a_reg * b_reg;
    assign mul_rnd16 = MUL_W'(mul + MUL_W'(32768)) >> 16;
    assign mul_rnd32 = MUL_W'(mul + (MUL_W'(1) << 31)) >> 32;

    // Restoring division step.
    assign rem_shift = {rem_reg, num_reg[31]};
    assign div_fits  = (rem_shift >= {1'b0, job_reg.span});

    // Mode selection of the half-curve argument.
    assign u_val  = num_reg[Q_W-1:0];
    assign v_wide = {u_val, 1'b0} - {1'b0, Q_ONE};
    always_comb
    begin
        split_val = 1'b0;
        upper_val = 1'b0;
        use_in    = 1'b1;
        v_val     = u_val;
        case (cfg.ease_mode)
            EM_IN:
            begin
                use_in = 1'b1;
            end
            EM_OUT:
            begin
                use_in = 1'b0;
            end
            default:
            begin
                split_val = 1'b1;
                if (u_val < Q_HALF)
                begin
                    v_val  = {u_val[Q_W-2:0], 1'b0};
                    use_in = (cfg.ease_mode == EM_IN_OUT);
                end
                else
                begin
                    v_val     = v_wide[Q_W-1:0];
                    upper_val = 1'b1;
                    use_in    = (cfg.ease_mode != EM_IN_OUT);
                end
            end
        endcase
    end
    assign xi = use_in ? v_val : Q_ONE - v_val;
    assign xs = Q_ONE - xi;

    // Sine polynomial step and final clamp.
    assign rs_val = rshift_rnd(mul, (state_reg == S_SIN_F) ? 30 : 16);
    assign horner = SINE_COEF[cnt_reg[2:0]] + rs_val[MUL_A_W-1:0];
    always_comb
    begin
        if (rs_val < 0)
        begin
            sine_p = '0;
        end
        else if (rs_val > $signed(MUL_W'(Q_ONE)))
        begin
            sine_p = Q_ONE;
        end
        else
        begin
            sine_p = rs_val[Q_W-1:0];
        end
    end

    // Square root digit step.
    assign sq_try      = sq_res_reg + sq_bit_reg;
    assign sq_take     = (sq_v_reg >= sq_try);
    assign sq_res_step = sq_take ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

    // Mode joining of the half curve.
    assign c_val  = flip_reg ? Q_ONE - cin_reg : cin_reg;
    assign g_half = ({1'b0, c_val} + 18'd1) >> 1;
    assign g_val  = split_reg ? g_half[Q_W-1:0] + (upper_reg ? Q_HALF : '0) : c_val;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty && !head_job.direct)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 8'd31)
                begin
                    state_next = S_MODE;
                end
            end
            S_MODE:
            begin
                if (v_val == '0 || v_val[Q_W-1])
                begin
                    state_next = S_POST;
                end
                else
                begin
                    case (cfg.curve_kind)
                        CK_QUAD:     state_next = S_QUAD;
                        CK_CUBIC:    state_next = S_CUB1;
                        CK_SINE:     state_next = S_SIN_X2;
                        CK_CIRCULAR: state_next = S_CIRC_SQ;
                        CK_POWER:    state_next = S_POW;
                        default:     state_next = S_POST;
                    endcase
                end
            end
            S_QUAD:    state_next = S_POST;
            S_CUB1:    state_next = S_CUB2;
            S_CUB2:    state_next = S_POST;
            S_SIN_X2:  state_next = S_SIN_H;
            S_SIN_H:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_SIN_F;
                end
            end
            S_SIN_F:   state_next = S_POST;
            S_CIRC_SQ: state_next = S_SQRT;
            S_SQRT:
            begin
                if (sq_bit_reg == 34'd1)
                begin
                    state_next = S_POST;
                end
            end
            S_POW:
            begin
                if (cnt_reg == cfg.poly_power)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:    state_next = S_SCALE;
            S_SCALE:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        job_next    = job_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        flip_next   = flip_reg;
        split_next  = split_reg;
        upper_next  = upper_reg;
        x_next      = x_reg;
        cin_next    = cin_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        sq_v_next   = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        rv_next     = 1'b0;
        res_next    = res_reg;
        pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    job_next = head_job;
                    if (head_job.direct)
                    begin
                        rv_next              = 1'b1;
                        res_next.eased_value = head_job.value;
                        res_next.status      = head_job.status;
                    end
                    else
                    begin
                        num_next = {head_job.offset, 16'd0} + 32'(head_job.span >> 1);
                        rem_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = div_fits ? DATA_W'(rem_shift - {1'b0, job_reg.span})
                                    : rem_shift[DATA_W-1:0];
                num_next = {num_reg[30:0], div_fits};
                cnt_next = cnt_reg + 8'd1;
            end
            S_MODE:
            begin
                split_next = split_val;
                upper_next = upper_val;
                flip_next  = 1'b0;
                x_next     = xi;
                a_next     = MUL_A_W'($signed({1'b0, xi}));
                b_next     = MUL_B_W'($signed({1'b0, xi}));
                if (v_val == '0)
                begin
                    cin_next = '0;
                end
                else if (v_val[Q_W-1])
                begin
                    cin_next = Q_ONE;
                end
                else
                begin
                    flip_next = !use_in;
                    cin_next  = xi;
                    if (cfg.curve_kind == CK_SINE)
                    begin
                        x_next = xs;
                        a_next = MUL_A_W'($signed({1'b0, xs}));
                        b_next = MUL_B_W'($signed({1'b0, xs}));
                    end
                    else if (cfg.curve_kind == CK_POWER)
                    begin
                        a_next   = MUL_A_W'($signed({1'b0, Q_ONE}));
                        cnt_next = '0;
                    end
                end
            end
            S_QUAD:
            begin
                cin_next = mul_rnd16[Q_W-1:0];
            end
            S_CUB1:
            begin
                a_next = mul[MUL_A_W-1:0];
                b_next = MUL_B_W'($signed({1'b0, x_reg}));
            end
            S_CUB2:
            begin
                cin_next = mul_rnd32[Q_W-1:0];
            end
            S_SIN_X2:
            begin
                a_next   = SINE_COEF[4];
                b_next   = MUL_B_W'($signed({1'b0, mul_rnd16[Q_W-1:0]}));
                cnt_next = 8'd3;
            end
            S_SIN_H:
            begin
                a_next = horner;
                if (cnt_reg == '0)
                begin
                    b_next = MUL_B_W'($signed({1'b0, x_reg}));
                end
                else
                begin
                    cnt_next = cnt_reg - 8'd1;
                end
            end
            S_SIN_F:
            begin
                cin_next = Q_ONE - sine_p;
            end
            S_CIRC_SQ:
            begin
                sq_v_next   = (34'd1 << 32) - mul[33:0];
                sq_res_next = '0;
                sq_bit_next = 34'd1 << 32;
            end
            S_SQRT:
            begin
                if (sq_take)
                begin
                    sq_v_next = sq_v_reg - sq_try;
                end
                sq_res_next = sq_res_step;
                sq_bit_next = sq_bit_reg >> 2;
                cin_next    = Q_ONE - sq_res_step[Q_W-1:0];
            end
            S_POW:
            begin
                if (cnt_reg == cfg.poly_power)
                begin
                    cin_next = a_reg[Q_W-1:0];
                end
                else
                begin
                    a_next   = MUL_A_W'($signed({1'b0, mul_rnd16[Q_W-1:0]}));
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            S_POST:
            begin
                a_next = MUL_A_W'($signed({1'b0, g_val}));
                b_next = MUL_B_W'($signed({1'b0, job_reg.span}));
            end
            S_SCALE:
            begin
                rv_next              = 1'b1;
                res_next.eased_value = job_reg.lo + mul_rnd16[DATA_W-1:0];
                res_next.status      = ST_OK;
            end
            default:
            begin
                rv_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        cnt_reg    <= cnt_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        flip_reg   <= flip_next;
        split_reg  <= split_next;
        upper_reg  <= upper_next;
        x_reg      <= x_next;
        cin_reg    <= cin_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        res_reg    <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire
